FILE: hw/rtl/i2crf_pkg.sv
// Shared types and constants for the I2C target register file.
// No dependencies; used by i2crf_core and i2c_target_register_file_top.
`default_nettype none

package i2crf_pkg;

  localparam int unsigned NUM_REGS_DEF = 16;
  localparam logic [6:0]  OWN_ADDR_RST = 7'd8;

  typedef struct packed {
    logic scl;
    logic sda;
  } in_item_t;

  typedef struct packed {
    logic       sda_pull_low;
    logic       write_strobe;
    logic [3:0] write_index;
    logic [7:0] write_value;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2crf_core.sv
// Bus sample decoder, protocol state and register bank of the I2C target.
// Depends on i2crf_pkg for the item types and reset constants.
`default_nettype none

module i2crf_core #(
  parameter int unsigned NUM_REGS = i2crf_pkg::NUM_REGS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  wire i2crf_pkg::in_item_t item_i,
  input  wire                   cfg_we_i,
  input  wire  [6:0]            cfg_wdata_i,
  output i2crf_pkg::out_item_t  result_o
);

  localparam int unsigned PTR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ADDRESS = 3'd1;
  localparam logic [2:0] PH_INDEX   = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_IGNORE  = 3'd4;
  localparam logic [2:0] PH_SEND    = 3'd5;

  logic [6:0]       own_addr_q;
  logic [2:0]       phase_q, phase_d;
  logic [3:0]       bit_cnt_q, bit_cnt_d;
  logic [7:0]       shift_q, shift_d;
  logic             pscl_q, pscl_d;
  logic             psda_q, psda_d;
  logic             acking_q, acking_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [7:0]       bank_q [NUM_REGS];
  logic             bank_we;

  logic [7:0] waddr, raddr, rd_byte, ptr_ext;
  logic       start, stop, rise, fall, idx_ok;

  assign waddr   = {own_addr_q, 1'b0};
  assign raddr   = {own_addr_q, 1'b1};
  assign rd_byte = bank_q[ptr_q];
  assign ptr_ext = 8'(ptr_q);
  assign idx_ok  = {1'b0, shift_q} < 9'(NUM_REGS);

  assign start = pscl_q & item_i.scl & psda_q & ~item_i.sda;
  assign stop  = pscl_q & item_i.scl & ~psda_q & item_i.sda;
  assign rise  = ~pscl_q & item_i.scl;
  assign fall  = pscl_q & ~item_i.scl;

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    acking_d  = acking_q;
    ptr_d     = ptr_q;
    bank_we   = 1'b0;
    pscl_d    = item_i.scl;
    psda_d    = item_i.sda;
    if (start) begin
      phase_d   = PH_ADDRESS;
      bit_cnt_d = 4'd0;
      shift_d   = 8'd0;
      acking_d  = 1'b0;
    end else if (stop) begin
      phase_d   = PH_IDLE;
      bit_cnt_d = 4'd0;
      acking_d  = 1'b0;
    end else if (phase_q != PH_IDLE && rise) begin
      if (phase_q == PH_SEND) begin
        if (bit_cnt_q == 4'd8) begin
          if (!item_i.sda) begin
            bit_cnt_d = 4'd9;
          end else begin
            phase_d   = PH_IDLE;
            bit_cnt_d = 4'd0;
          end
        end
      end else if (bit_cnt_q < 4'd8) begin
        shift_d   = {shift_q[6:0], item_i.sda};
        bit_cnt_d = bit_cnt_q + 4'd1;
      end
    end else if (phase_q != PH_IDLE && fall) begin
      if (phase_q == PH_SEND) begin
        if (bit_cnt_q < 4'd7) begin
          shift_d   = {shift_q[6:0], 1'b0};
          bit_cnt_d = bit_cnt_q + 4'd1;
        end else if (bit_cnt_q == 4'd7) begin
          bit_cnt_d = 4'd8;
        end else if (bit_cnt_q == 4'd9) begin
          shift_d   = rd_byte;
          bit_cnt_d = 4'd0;
        end
      end else if (bit_cnt_q == 4'd8) begin
        acking_d = 1'b0;
        case (phase_q)
          PH_ADDRESS: begin
            if (shift_q == waddr) begin
              phase_d  = PH_INDEX;
              acking_d = 1'b1;
            end else if (shift_q == raddr) begin
              phase_d  = PH_SEND;
              acking_d = 1'b1;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_INDEX: begin
            if (idx_ok) begin
              ptr_d    = PTR_W'(shift_q);
              acking_d = 1'b1;
            end
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            bank_we  = 1'b1;
            acking_d = 1'b1;
            phase_d  = PH_IGNORE;
          end
          default: begin
          end
        endcase
        bit_cnt_d = (phase_d == PH_IDLE) ? 4'd0 : 4'd9;
      end else if (bit_cnt_q == 4'd9) begin
        acking_d  = 1'b0;
        bit_cnt_d = 4'd0;
        shift_d   = (phase_q == PH_SEND) ? rd_byte : 8'd0;
      end
    end
  end

  always_comb begin
    result_o.write_strobe = bank_we;
    result_o.write_index  = bank_we ? ptr_ext[3:0] : 4'd0;
    result_o.write_value  = bank_we ? shift_q : 8'd0;
    if (phase_d == PH_SEND && bit_cnt_d < 4'd8 && !acking_d) begin
      result_o.sda_pull_low = ~shift_d[7];
    end else begin
      result_o.sda_pull_low = acking_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= i2crf_pkg::OWN_ADDR_RST;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= 4'd0;
      shift_q   <= 8'd0;
      pscl_q    <= 1'b1;
      psda_q    <= 1'b1;
      acking_q  <= 1'b0;
      ptr_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      pscl_q    <= pscl_d;
      psda_q    <= psda_d;
      acking_q  <= acking_d;
      ptr_q     <= ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        bank_q[i] <= 8'd0;
      end
    end else if (step_i && bank_we) begin
      bank_q[ptr_q] <= shift_q;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> bit_cnt_q == 4'd0)
    else $error("idle phase with bit count pending");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= 4'd9)
    else $error("bit count out of range");

  a_strobe_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.write_strobe |=> acking_q && phase_q == PH_IGNORE)
    else $error("stored byte not acknowledged");

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_target_register_file_top.sv
// I2C target with a register file: one bus sample in, one result out.
// Each accepted item's result is registered in out_q, or in the skid stage while the output stalls.
// Throughput: one item per cycle while in_stall_o is low, set by the single result register and skid stage.
// in_stall_o rises only while the skid stage holds a result the output has not taken.
// Reset clears the protocol state, the register bank and own_address (to 8).
// Depends on i2crf_pkg and i2crf_core.
`default_nettype none

module i2c_target_register_file_top #(
  parameter int unsigned NUM_REGS = i2crf_pkg::NUM_REGS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire i2crf_pkg::in_item_t in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output i2crf_pkg::out_item_t  out_data_o,
  input  wire                   cfg_we_i,
  input  wire  [6:0]            cfg_wdata_i
);

  logic                 in_acc, out_take;
  logic                 out_valid_q, skid_valid_q;
  i2crf_pkg::out_item_t res, out_q, skid_q;

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i & ~skid_valid_q;
  assign out_take    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  i2crf_core #(
    .NUM_REGS (NUM_REGS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      out_valid_q  <= skid_valid_q | in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && out_valid_q && out_stall_i |=> skid_valid_q)
    else $error("accepted item lost under output stall");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_take |=> out_valid_q && !skid_valid_q)
    else $error("skid item not moved to output");

endmodule

`default_nettype wire

FILE: test/i2c_target_register_file_top_test.sv
// Self-checking bench for i2c_target_register_file_top: drives bus samples, tracks the target.
// Depends on i2crf_pkg and the top level; runs directed bus rows, then random transactions.
`default_nettype none

module i2c_target_register_file_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADDR, ST_INDEX, ST_STORE, ST_DISCARD, ST_SEND
  } bus_state_e;

  typedef enum logic [2:0] {
    OP_IDLE, OP_START, OP_STOP, OP_BYTE, OP_SKEW, OP_READ
  } bus_op_e;

  typedef struct packed {
    bus_op_e    op;
    logic [7:0] value;
    logic       typed;
    logic       exp_pull;
  } bus_row_t;

  typedef struct packed {
    i2crf_pkg::in_item_t smp;
    logic                chk;
    logic                pull;
  } bus_sample_t;

  localparam int NREGS = i2crf_pkg::NUM_REGS_DEF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  i2crf_pkg::in_item_t  in_data = '{scl: 1'b1, sda: 1'b1};
  logic                 tag_chk = 1'b0;
  logic                 tag_pull = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  i2crf_pkg::out_item_t out_data;
  logic                 cfg_we = 1'b0;
  logic [6:0]           cfg_wdata = i2crf_pkg::OWN_ADDR_RST;

  bus_state_e st_q;
  logic [3:0] bits_q;
  logic [7:0] shift_q;
  logic       scl_d;
  logic       sda_d;
  logic       ack_q;
  logic [3:0] ptr_q;
  logic [7:0] bank_q [NREGS];
  logic [6:0] own_q;

  bus_sample_t          bus_q [$];
  i2crf_pkg::out_item_t due_outputs [$];
  bus_row_t             dir_rows [0:24];
  logic                 line_scl = 1'b1;
  logic                 line_sda = 1'b1;
  int                   burst_left = 0;
  int                   mismatches = 0;
  int                   stall_cnt = 0;
  int                   stall_mode = 0;

  i2c_target_register_file_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic target_reset();
    st_q = ST_IDLE;
    bits_q = 4'd0;
    shift_q = 8'd0;
    scl_d = 1'b1;
    sda_d = 1'b1;
    ack_q = 1'b0;
    ptr_q = 4'd0;
    own_q = i2crf_pkg::OWN_ADDR_RST;
    foreach (bank_q[i]) bank_q[i] = 8'd0;
  endtask

  task automatic track_target(input i2crf_pkg::in_item_t s, output i2crf_pkg::out_item_t r);
    logic [7:0] waddr;
    logic [7:0] raddr;
    waddr = {own_q, 1'b0};
    raddr = waddr | 8'h01;
    r = '0;
    if (scl_d && s.scl && sda_d && !s.sda) begin
      st_q = ST_ADDR;
      bits_q = 4'd0;
      shift_q = 8'd0;
      ack_q = 1'b0;
    end else if (scl_d && s.scl && !sda_d && s.sda) begin
      st_q = ST_IDLE;
      bits_q = 4'd0;
      ack_q = 1'b0;
    end else if (st_q != ST_IDLE && !scl_d && s.scl) begin
      if (st_q == ST_SEND) begin
        if (bits_q == 4'd8) begin
          if (!s.sda) begin
            bits_q = 4'd9;
          end else begin
            st_q = ST_IDLE;
            bits_q = 4'd0;
          end
        end
      end else if (bits_q < 4'd8) begin
        shift_q = {shift_q[6:0], s.sda};
        bits_q = bits_q + 4'd1;
      end
    end else if (st_q != ST_IDLE && scl_d && !s.scl) begin
      if (st_q == ST_SEND) begin
        if (bits_q < 4'd7) begin
          shift_q = {shift_q[6:0], 1'b0};
          bits_q = bits_q + 4'd1;
        end else if (bits_q == 4'd7) begin
          bits_q = 4'd8;
        end else if (bits_q == 4'd9) begin
          shift_q = bank_q[ptr_q];
          bits_q = 4'd0;
        end
      end else if (bits_q == 4'd8) begin
        ack_q = 1'b0;
        case (st_q)
          ST_ADDR: begin
            if (shift_q == waddr) begin
              st_q = ST_INDEX;
              ack_q = 1'b1;
            end else if (shift_q == raddr) begin
              st_q = ST_SEND;
              ack_q = 1'b1;
            end else begin
              st_q = ST_IDLE;
            end
          end
          ST_INDEX: begin
            if (shift_q < NREGS) begin
              ptr_q = shift_q[3:0];
              ack_q = 1'b1;
            end
            st_q = ST_STORE;
          end
          ST_STORE: begin
            bank_q[ptr_q] = shift_q;
            r.write_strobe = 1'b1;
            r.write_index = ptr_q;
            r.write_value = shift_q;
            ack_q = 1'b1;
            st_q = ST_DISCARD;
          end
          default: ;
        endcase
        bits_q = (st_q == ST_IDLE) ? 4'd0 : 4'd9;
      end else if (bits_q == 4'd9) begin
        ack_q = 1'b0;
        bits_q = 4'd0;
        shift_q = 8'd0;
      end
    end
    scl_d = s.scl;
    sda_d = s.sda;
    if (st_q == ST_SEND && bits_q < 4'd8 && !ack_q) begin
      r.sda_pull_low = ~shift_q[7];
    end else begin
      r.sda_pull_low = ack_q;
    end
  endtask

  task automatic report_mismatch(input i2crf_pkg::out_item_t want,
                                 input i2crf_pkg::out_item_t got, input bit stray);
    mismatches++;
    if (mismatches <= 10) begin
      if (stray) begin
        $display("stray item: got pull=%0b strobe=%0b index=%0d value=%02h",
                 got.sda_pull_low, got.write_strobe, got.write_index, got.write_value);
      end else begin
        $display("mismatch: expected pull=%0b strobe=%0b index=%0d value=%02h",
                 want.sda_pull_low, want.write_strobe, want.write_index, want.write_value);
        $display("          got      pull=%0b strobe=%0b index=%0d value=%02h",
                 got.sda_pull_low, got.write_strobe, got.write_index, got.write_value);
      end
    end
  endtask

  always @(posedge clk) begin
    i2crf_pkg::out_item_t want;
    i2crf_pkg::out_item_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_outputs.size() == 0) begin
          report_mismatch('0, out_data, 1'b1);
        end else begin
          want = due_outputs.pop_front();
          if (out_data.sda_pull_low !== want.sda_pull_low ||
              out_data.write_strobe !== want.write_strobe ||
              out_data.write_index !== want.write_index ||
              out_data.write_value !== want.write_value) begin
            report_mismatch(want, out_data, 1'b0);
          end
        end
      end
      if (in_valid && !in_stall) begin
        track_target(in_data, pred);
        if (tag_chk) pred.sda_pull_low = tag_pull;
        due_outputs.push_back(pred);
      end
      if (cfg_we) own_q = cfg_wdata;
    end
  end

  always @(negedge clk) begin
    if (stall_cnt % 50 == 0) stall_mode = $urandom_range(0, 3);
    stall_cnt++;
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= (stall_cnt % 4 == 0);
      3: out_stall <= (stall_cnt % 16 < 6);
      default: out_stall <= 1'b0;
    endcase
  end

  function automatic int hold_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
  endfunction

  task automatic emit(input logic c, input logic d, input int reps, input logic chk,
                      input logic pull);
    bus_sample_t e;
    e.smp.scl = c;
    e.smp.sda = d;
    e.chk = chk;
    e.pull = pull;
    repeat (reps) bus_q.push_back(e);
    line_scl = c;
    line_sda = d;
  endtask

  task automatic put_bit(input logic b, input int skew_pct, input logic chk, input logic pull);
    logic skew;
    logic merge_fall;
    skew = ($urandom_range(0, 99) < skew_pct);
    merge_fall = skew && ($urandom_range(0, 1) == 1);
    if (merge_fall) begin
      emit(1'b0, b, hold_len(), 1'b0, 1'b0);
    end else begin
      emit(1'b0, line_sda, hold_len(), 1'b0, 1'b0);
      if (!skew) emit(1'b0, b, hold_len(), 1'b0, 1'b0);
    end
    emit(1'b1, b, hold_len(), chk, pull);
  endtask

  task automatic put_byte(input logic [7:0] v, input logic ack_bit, input int skew_pct,
                          input logic chk, input logic pull);
    for (int i = 7; i >= 0; i--) put_bit(v[i], skew_pct, 1'b0, 1'b0);
    put_bit(ack_bit, skew_pct, chk, pull);
  endtask

  task automatic bus_start();
    if (!(line_scl && line_sda)) begin
      if (line_scl) emit(1'b0, line_sda, hold_len(), 1'b0, 1'b0);
      emit(1'b0, 1'b1, hold_len(), 1'b0, 1'b0);
      emit(1'b1, 1'b1, hold_len(), 1'b0, 1'b0);
    end
    emit(1'b1, 1'b0, hold_len(), 1'b0, 1'b0);
  endtask

  task automatic bus_stop();
    if (!(line_scl && !line_sda)) begin
      if (line_scl) emit(1'b0, line_sda, hold_len(), 1'b0, 1'b0);
      emit(1'b0, 1'b0, hold_len(), 1'b0, 1'b0);
      emit(1'b1, 1'b0, hold_len(), 1'b0, 1'b0);
    end
    emit(1'b1, 1'b1, hold_len(), 1'b0, 1'b0);
  endtask

  task automatic gen_directed();
    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        OP_IDLE:  emit(1'b1, 1'b1, 3, dir_rows[i].typed, dir_rows[i].exp_pull);
        OP_START: bus_start();
        OP_STOP:  bus_stop();
        OP_BYTE:  put_byte(dir_rows[i].value, 1'b1, 0, dir_rows[i].typed,
                           dir_rows[i].exp_pull);
        OP_SKEW:  put_byte(dir_rows[i].value, 1'b1, 100, dir_rows[i].typed,
                           dir_rows[i].exp_pull);
        OP_READ:  put_byte(8'($urandom), dir_rows[i].value[0], 0, dir_rows[i].typed,
                           dir_rows[i].exp_pull);
        default: ;
      endcase
    end
  endtask

  task automatic gen_transaction(input logic [6:0] own);
    int kind;
    int n;
    logic [7:0] waddr;
    logic [7:0] addr;
    logic last_ack;
    kind = $urandom_range(0, 99);
    waddr = {own, 1'b0};
    if (kind < 45) begin
      bus_start();
      addr = ($urandom_range(0, 4) != 0) ? waddr : 8'($urandom_range(0, 255));
      put_byte(addr, 1'($urandom_range(0, 1)), 8, 1'b0, 1'b0);
      addr = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 15))
                                         : 8'($urandom_range(0, 255));
      put_byte(addr, 1'($urandom_range(0, 1)), 8, 1'b0, 1'b0);
      put_byte(8'($urandom), 1'($urandom_range(0, 1)), 8, 1'b0, 1'b0);
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'($urandom_range(0, 1)), 8,
                                             1'b0, 1'b0);
      if ($urandom_range(0, 4) != 0) bus_stop();
    end else if (kind < 80) begin
      bus_start();
      addr = ($urandom_range(0, 4) != 0) ? (waddr | 8'h01) : 8'($urandom_range(0, 255));
      put_byte(addr, 1'($urandom_range(0, 1)), 8, 1'b0, 1'b0);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        last_ack = (i == n - 1);
        if ($urandom_range(0, 9) == 0) last_ack = ~last_ack;
        put_byte(8'($urandom), last_ack, 8, 1'b0, 1'b0);
      end
      if ($urandom_range(0, 4) != 0) bus_stop();
    end else if (kind < 90) begin
      repeat ($urandom_range(4, 16)) begin
        emit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1, 1'b0, 1'b0);
      end
    end else begin
      bus_start();
      repeat ($urandom_range(1, 12)) put_bit(1'($urandom_range(0, 1)), 8, 1'b0, 1'b0);
      if ($urandom_range(0, 1) == 1) bus_stop();
    end
  endtask

  task automatic send_sample(input bus_sample_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= e.smp;
    tag_chk <= e.chk;
    tag_pull <= e.pull;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drive_all();
    while (bus_q.size() != 0) send_sample(bus_q.pop_front());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [6:0] phase_addr [4];
    dir_rows = '{
      '{OP_IDLE,  8'h00, 1'b1, 1'b0},
      '{OP_START, 8'h00, 1'b0, 1'b0},
      '{OP_BYTE,  8'h10, 1'b1, 1'b1},
      '{OP_BYTE,  8'h03, 1'b1, 1'b1},
      '{OP_BYTE,  8'hFF, 1'b1, 1'b1},
      '{OP_BYTE,  8'h00, 1'b1, 1'b0},
      '{OP_STOP,  8'h00, 1'b0, 1'b0},
      '{OP_START, 8'h00, 1'b0, 1'b0},
      '{OP_BYTE,  8'h10, 1'b1, 1'b1},
      '{OP_BYTE,  8'h10, 1'b1, 1'b0},
      '{OP_BYTE,  8'hA5, 1'b1, 1'b1},
      '{OP_START, 8'h00, 1'b0, 1'b0},
      '{OP_BYTE,  8'h11, 1'b1, 1'b1},
      '{OP_READ,  8'h00, 1'b0, 1'b0},
      '{OP_READ,  8'h01, 1'b0, 1'b0},
      '{OP_STOP,  8'h00, 1'b0, 1'b0},
      '{OP_START, 8'h00, 1'b0, 1'b0},
      '{OP_BYTE,  8'h22, 1'b1, 1'b0},
      '{OP_STOP,  8'h00, 1'b0, 1'b0},
      '{OP_START, 8'h00, 1'b0, 1'b0},
      '{OP_SKEW,  8'h10, 1'b1, 1'b1},
      '{OP_BYTE,  8'h0F, 1'b1, 1'b1},
      '{OP_BYTE,  8'h5A, 1'b1, 1'b1},
      '{OP_STOP,  8'h00, 1'b0, 1'b0},
      '{OP_IDLE,  8'h00, 1'b1, 1'b0}
    };
    phase_addr[0] = 7'd0;
    phase_addr[1] = 7'd127;
    phase_addr[2] = 7'($urandom_range(0, 127));
    phase_addr[3] = 7'($urandom_range(0, 127));
    target_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    gen_directed();
    drive_all();
    foreach (phase_addr[p]) begin
      settle();
      cfg_we <= 1'b1;
      cfg_wdata <= phase_addr[p];
      @(negedge clk);
      cfg_we <= 1'b0;
      while (bus_q.size() < 40) gen_transaction(phase_addr[p]);
      drive_all();
    end
    settle();
    if (mismatches == 0 && due_outputs.size() == 0) begin
      $display("i2c_target_register_file_top_test: PASS");
    end else begin
      $display("i2c_target_register_file_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("i2c_target_register_file_top_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/i2crf_pkg.sv
hw/rtl/i2crf_core.sv
hw/rtl/i2c_target_register_file_top.sv
test/i2c_target_register_file_top_test.sv
